@@ hdl/assert_macros.svh @@
// assertion macros used by the top rtl file of the ir frame encoder
// depends on nothing; files that assert take it with an include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/ipdfe_pkg.sv @@
// types and constants of the ir pulse distance frame encoder
// depends on nothing
package ipdfe_pkg;

    localparam logic [12:0] HDR_MARK_US   = 13'd8000;
    localparam logic [12:0] BIT_MARK_US   = 13'd526;
    localparam logic [14:0] HDR_SPACE_US  = 15'd4000;
    localparam logic [14:0] ZERO_SPACE_US = 15'd474;
    localparam logic [14:0] ONE_SPACE_US  = 15'd1474;
    // footer space with no one bits; each one bit takes a further unit away
    localparam logic [14:0] FOOTER_BASE_US = 15'd26948;
    localparam logic [14:0] UNIT_US        = 15'd1000;
    localparam logic [14:0] FOOTER_MIN_US  = 15'd10948;

    // pair positions inside one repetition
    localparam logic [4:0] PAIR_HDR    = 5'd0;
    localparam logic [4:0] PAIR_SEP    = 5'd9;
    localparam logic [4:0] PAIR_FOOTER = 5'd18;

    localparam logic [5:0] SPLIT_BITS_RESET = 6'd16;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // control from the sequencer to the code shift register
    typedef struct packed {
        logic load;   // take a fresh address/command pair
        logic shift;  // one code bit was sent
        logic rearm;  // footer sent, restart the space count
    } shreg_ctrl_t;

endpackage

@@ hdl/ir_pulse_distance_frame_encoder_unit.sv @@
// top level of the ir pulse distance frame encoder: handshakes, sequencer, output register
// depends on ipdfe_pkg, ipdfe_code_shreg and assert_macros.svh
//
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   data_word[31:0], repeat_count[1:0]
// output    out        out_valid / out_stall mark_us[12:0], space_us[14:0], last
// config    in         cfg_wen               cfg_wdata[5:0] -> split_bits
//
// one item is accepted and then sent as 19 pairs per repetition, up to three
// repetitions; the pair sequencer emits one pair a cycle unless out_stall holds it
// a repeat count of zero is accepted and leaves with no result
// reset clears the sequencer and output valid, split_bits returns to 16
// out_stall freezes the output register and the sequencer together while out_valid is high;
// in_stall is high for the whole run of an item
`include "assert_macros.svh"

module ir_pulse_distance_frame_encoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [5:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [1:0]  repeat_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [12:0] mark_us,
    output logic [14:0] space_us,
    output logic        last
);

    ipdfe_pkg::state_t      state_reg, state_next;
    ipdfe_pkg::shreg_ctrl_t sr_ctrl;

    logic [5:0]  split_bits_reg;
    logic [1:0]  rep_left_reg, rep_left_next;
    logic [4:0]  pair_idx_reg, pair_idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [12:0] mark_reg, mark_next;
    logic [14:0] space_reg, space_next;
    logic        last_reg, last_next;

    logic        accept;
    logic        gen_en;
    logic        is_bit_pair;
    logic        is_footer;
    logic        code_bit;
    logic [14:0] footer_space;
    logic [4:0]  half;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [7:0]  cmd_mask;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_bits_reg <= ipdfe_pkg::SPLIT_BITS_RESET;
        end
        else if (cfg_wen)
        begin
            split_bits_reg <= cfg_wdata;
        end
    end

    // field split: address is the word shifted by half, command the low half bits of the low byte
    assign half = split_bits_reg[5:1];
    assign addr = 8'(data_word >> half);
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            cmd_mask[i] = (5'(i) < half);
        end
    end
    assign cmd = data_word[7:0] & cmd_mask;

    assign in_stall = (state_reg != ipdfe_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // while running, a pair is produced whenever the output register is free or emptying
    assign gen_en = (state_reg == ipdfe_pkg::ST_RUN) && (!out_valid_reg || !out_stall);

    assign is_footer   = (pair_idx_reg == ipdfe_pkg::PAIR_FOOTER);
    assign is_bit_pair = (pair_idx_reg != ipdfe_pkg::PAIR_HDR)
                      && (pair_idx_reg != ipdfe_pkg::PAIR_SEP)
                      && !is_footer;

    assign sr_ctrl.load  = accept;
    assign sr_ctrl.shift = gen_en && is_bit_pair;
    assign sr_ctrl.rearm = gen_en && is_footer;

    ipdfe_code_shreg u_shreg
    (
        .clk          (clk),
        .ctrl         (sr_ctrl),
        .addr         (addr),
        .cmd          (cmd),
        .code_bit     (code_bit),
        .footer_space (footer_space)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        rep_left_next = rep_left_reg;
        pair_idx_next = pair_idx_reg;
        case (state_reg)
            ipdfe_pkg::ST_IDLE:
            begin
                if (accept && (repeat_count != 2'd0))
                begin
                    state_next    = ipdfe_pkg::ST_RUN;
                    rep_left_next = repeat_count - 2'd1;
                    pair_idx_next = ipdfe_pkg::PAIR_HDR;
                end
            end
            ipdfe_pkg::ST_RUN:
            begin
                if (gen_en)
                begin
                    if (is_footer)
                    begin
                        pair_idx_next = ipdfe_pkg::PAIR_HDR;
                        if (rep_left_reg == 2'd0)
                        begin
                            state_next = ipdfe_pkg::ST_IDLE;
                        end
                        else
                        begin
                            rep_left_next = rep_left_reg - 2'd1;
                        end
                    end
                    else
                    begin
                        pair_idx_next = pair_idx_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = ipdfe_pkg::ST_IDLE;
            end
        endcase
    end

    // pair contents for the current position
    always_comb
    begin
        out_valid_next = out_valid_reg;
        mark_next      = mark_reg;
        space_next     = space_reg;
        last_next      = last_reg;
        if (gen_en)
        begin
            out_valid_next = 1'b1;
            last_next      = is_footer && (rep_left_reg == 2'd0);
            if (pair_idx_reg == ipdfe_pkg::PAIR_HDR)
            begin
                mark_next  = ipdfe_pkg::HDR_MARK_US;
                space_next = ipdfe_pkg::HDR_SPACE_US;
            end
            else if (pair_idx_reg == ipdfe_pkg::PAIR_SEP)
            begin
                mark_next  = ipdfe_pkg::BIT_MARK_US;
                space_next = ipdfe_pkg::HDR_SPACE_US;
            end
            else if (is_footer)
            begin
                mark_next  = ipdfe_pkg::BIT_MARK_US;
                space_next = footer_space;
            end
            else
            begin
                mark_next  = ipdfe_pkg::BIT_MARK_US;
                space_next = code_bit ? ipdfe_pkg::ONE_SPACE_US : ipdfe_pkg::ZERO_SPACE_US;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ipdfe_pkg::ST_IDLE;
            rep_left_reg  <= 2'd0;
            pair_idx_reg  <= ipdfe_pkg::PAIR_HDR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rep_left_reg  <= rep_left_next;
            pair_idx_reg  <= pair_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        mark_reg  <= mark_next;
        space_reg <= space_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign mark_us   = mark_reg;
    assign space_us  = space_reg;
    assign last      = last_reg;

    // checks
    `ASSERT_CLK(a_pair_idx_range,
        (pair_idx_reg <= ipdfe_pkg::PAIR_FOOTER),
        "pair index past footer")
    `ASSERT_CLK(a_last_is_footer,
        (out_valid_reg && last_reg) |-> ((mark_reg == ipdfe_pkg::BIT_MARK_US)
            && (space_reg >= ipdfe_pkg::FOOTER_MIN_US)),
        "last pair is not a footer")
    `ASSERT_CLK(a_accept_starts_run,
        (accept && (repeat_count != 2'd0)) |=> ((state_reg == ipdfe_pkg::ST_RUN)
            && (pair_idx_reg == ipdfe_pkg::PAIR_HDR)),
        "run did not start at header")
    `ASSERT_CLK(a_stall_holds_pair,
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(space_reg)
            && $stable(pair_idx_reg)),
        "sequencer moved under output stall")

endmodule

@@ hdl/ipdfe_code_shreg.sv @@
// rotating code bit shift register and footer space counter
// depends on ipdfe_pkg
module ipdfe_code_shreg
(
    input  logic                   clk,
    input  ipdfe_pkg::shreg_ctrl_t ctrl,
    input  logic [7:0]             addr,
    input  logic [7:0]             cmd,
    output logic                   code_bit,
    output logic [14:0]            footer_space
);

    logic [15:0] bits_reg;
    logic [15:0] bits_next;
    logic [14:0] acc_reg;
    logic [14:0] acc_next;

    always_comb
    begin
        bits_next = bits_reg;
        acc_next  = acc_reg;
        if (ctrl.load)
        begin
            bits_next = {addr, cmd};
            acc_next  = ipdfe_pkg::FOOTER_BASE_US;
        end
        else
        begin
            if (ctrl.shift)
            begin
                // rotate so the code is back in place after sixteen bits
                bits_next = {bits_reg[14:0], bits_reg[15]};
                if (bits_reg[15])
                begin
                    acc_next = acc_reg - ipdfe_pkg::UNIT_US;
                end
            end
            if (ctrl.rearm)
            begin
                acc_next = ipdfe_pkg::FOOTER_BASE_US;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        acc_reg  <= acc_next;
    end

    assign code_bit     = bits_reg[15];
    assign footer_space = acc_reg;

endmodule

@@ bench/ir_pulse_distance_frame_encoder_unit_test.sv @@
// self-checking bench for ir_pulse_distance_frame_encoder_unit: directed and random code words
// depends only on the rtl; pulse pairs are predicted here and checked in order of arrival
module ir_pulse_distance_frame_encoder_unit_test;

    localparam int unsigned HDR_MARK     = 8000;
    localparam int unsigned HDR_SPACE    = 4000;
    localparam int unsigned BIT_MARK     = 526;
    localparam int unsigned ZERO_SPACE   = 474;
    localparam int unsigned ONE_SPACE    = 1474;
    localparam int unsigned FRAME_LEN    = 60000;
    localparam int unsigned UNIT_LEN     = 1000;
    localparam int unsigned FRAME_FIXED  = 17052;
    localparam int unsigned PAIRS_PER_REP = 19;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          STUCK_LIMIT  = 4000;
    localparam int          PRINT_CAP    = 50;
    localparam int          ITEMS_PER_SETTING = 44;

    typedef struct packed {
        logic [12:0] mark;
        logic [14:0] space;
        logic        last;
    } pulse_pair_t;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  reps;
    } code_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [5:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] data_word;
    logic [1:0]  repeat_count;
    logic        out_valid;
    logic        out_stall;
    logic [12:0] mark_us;
    logic [14:0] space_us;
    logic        last;

    code_item_t  pending_codes[$];
    pulse_pair_t expected_pairs[$];
    logic [5:0]  split_len;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatches;
    int          stuck_cycles;

    ir_pulse_distance_frame_encoder_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_word    (data_word),
        .repeat_count (repeat_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mark_us      (mark_us),
        .space_us     (space_us),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic push_pair(input int unsigned m, input int unsigned s, input bit fin);
        pulse_pair_t p;
        p.mark  = 13'(m);
        p.space = 15'(s);
        p.last  = fin;
        expected_pairs.push_back(p);
    endtask

    // expected pulse pairs for one accepted code word at the current code length
    task automatic predict_frames(input logic [31:0] word, input logic [1:0] reps);
        logic [4:0]  half;
        logic [7:0]  addr;
        logic [7:0]  cmd;
        logic [63:0] cmask;
        logic [15:0] bits;
        int unsigned ones;
        int unsigned gap;
        int unsigned total;
        int unsigned k;
        half  = split_len[5:1];
        addr  = 8'(word >> half);
        cmask = (64'd1 << half) - 64'd1;
        cmd   = 8'({32'd0, word} & cmask);
        bits  = {addr, cmd};
        ones  = $countones(bits);
        gap   = FRAME_LEN - UNIT_LEN * (16 + ones) - FRAME_FIXED;
        total = PAIRS_PER_REP * reps;
        k     = 0;
        for (int r = 0; r < reps; r++)
        begin
            push_pair(HDR_MARK, HDR_SPACE, k == total - 1);
            k++;
            for (int b = 15; b >= 0; b--)
            begin
                push_pair(BIT_MARK, bits[b] ? ONE_SPACE : ZERO_SPACE, k == total - 1);
                k++;
                // separator between address and command
                if (b == 8)
                begin
                    push_pair(BIT_MARK, HDR_SPACE, k == total - 1);
                    k++;
                end
            end
            push_pair(BIT_MARK, gap, k == total - 1);
            k++;
        end
    endtask

    // driver: holds each item until accepted, then takes the next one or idles
    always @(posedge clk)
    begin
        code_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_frames(data_word, repeat_count);
            if (!in_valid || !in_stall)
            begin
                if (pending_codes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_codes.pop_front();
                    in_valid     <= 1'b1;
                    data_word    <= nxt.word;
                    repeat_count <= nxt.reps;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each accepted pair with the oldest expectation
    always @(posedge clk)
    begin
        pulse_pair_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pairs.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected pair mark %0d space %0d last %0b",
                                              mark_us, space_us, last));
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (mark_us !== want.mark)
                        report_mismatch($sformatf("mark_us got %0d want %0d",
                                                  mark_us, want.mark));
                    if (space_us !== want.space)
                        report_mismatch($sformatf("space_us got %0d want %0d",
                                                  space_us, want.space));
                    if (last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  last, want.last));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("ir_pulse_distance_frame_encoder_unit_test NOT OK");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic queue_code(input logic [31:0] word, input logic [1:0] reps);
        code_item_t it;
        it.word = word;
        it.reps = reps;
        pending_codes.push_back(it);
    endtask

    // all items sent, all pairs seen, then room for a zero-repeat item to finish
    task automatic wait_drained();
        while (pending_codes.size() > 0 || in_valid || expected_pairs.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_split(input logic [5:0] v);
        wait_drained();
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        split_len  = v;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    function automatic logic [31:0] random_word();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'(1) << $urandom_range(0, 31);
            3: return 32'($urandom_range(0, 255)) << (8 * $urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] random_reps();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        return (pick == 0) ? 2'd0 : 2'(1 + pick % 3);
    endfunction

    initial
    begin
        logic [5:0] settings[3][3];
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = 6'd0;
        in_valid      = 1'b0;
        data_word     = 32'd0;
        repeat_count  = 2'd0;
        out_stall     = 1'b0;
        split_len     = 6'd16;
        send_idle_pct = 8;
        recv_idle_pct = 71;
        mismatches    = 0;
        stuck_cycles  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset length of 16, extremes of the word, every repeat count
        queue_code(32'h0000_0000, 2'd1);
        queue_code(32'hFFFF_FFFF, 2'd3);
        queue_code(32'h0000_A55A, 2'd2);
        queue_code(32'h1234_5678, 2'd0);
        queue_code(32'h1234_5678, 2'd1);
        queue_code(32'h0000_00FF, 2'd1);
        queue_code(32'h0000_FF00, 2'd1);
        // zero length: address is the low byte, command is zero
        write_split(6'd0);
        queue_code(32'hFFFF_FFFF, 2'd1);
        queue_code(32'h0000_00A5, 2'd2);
        write_split(6'd1);
        queue_code(32'h0000_005A, 2'd1);
        // lengths above thirty-two shift by 16 to 31
        write_split(6'd63);
        queue_code(32'hFFFF_FFFF, 2'd1);
        queue_code(32'h8000_0000, 2'd1);
        queue_code(32'h7FFF_FFFF, 2'd0);
        write_split(6'd33);
        queue_code(32'hA5A5_A5A5, 2'd1);
        write_split(6'd32);
        queue_code(32'hFFFF_00FF, 2'd1);
        queue_code(32'h00FF_FF00, 2'd3);
        write_split(6'd2);
        queue_code(32'h0000_0003, 2'd1);

        settings = '{'{6'd0, 6'd32, 6'd16},
                     '{6'd63, 6'd1, 6'($urandom_range(0, 63))},
                     '{6'($urandom_range(0, 63)), 6'd33, 6'($urandom_range(0, 63))}};
        for (int ph = 0; ph < 3; ph++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                write_split(settings[ph][s]);
                case (ph)
                    0:
                    begin
                        send_idle_pct = 8;
                        recv_idle_pct = 71;
                    end
                    1:
                    begin
                        send_idle_pct = 71;
                        recv_idle_pct = 8;
                    end
                    default:
                    begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                for (int i = 0; i < ITEMS_PER_SETTING; i++)
                    queue_code(random_word(), random_reps());
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("ir_pulse_distance_frame_encoder_unit_test OK");
        else
            $display("ir_pulse_distance_frame_encoder_unit_test NOT OK");
        $finish;
    end

endmodule

@@ ir_pulse_distance_frame_encoder_unit.f @@
+incdir+hdl
hdl/ipdfe_pkg.sv
hdl/ipdfe_code_shreg.sv
hdl/ir_pulse_distance_frame_encoder_unit.sv
bench/ir_pulse_distance_frame_encoder_unit_test.sv
